/* rtl/rogw_pkg.sv */
// rogw_pkg: shared constants, codes and types for the rectangle occupancy grid
// no dependencies; imported by the channel interfaces, the divider and the top level
`timescale 1ns / 1ps

package rogw_pkg;

	// grid geometry
	localparam int GRID_COLUMNS = 64;
	localparam int GRID_ROWS    = 64;
	localparam int CELL_COUNT   = GRID_COLUMNS * GRID_ROWS;

	localparam int COL_W  = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
	localparam int ROW_W  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
	localparam int ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

	// field widths
	localparam int KIND_W     = 2;
	localparam int POS_W      = 15;
	localparam int SUM_W      = 16;
	localparam int CELL_W     = 11;
	localparam int GRID_W     = 16;
	localparam int SPAN_W     = 17;
	localparam int CHG_W      = 13;
	localparam int WGT_W      = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic [CHG_W-1:0] CHG_MAX = '1;
	localparam logic [WGT_W-1:0] WGT_MAX = '1;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD    = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_READ   = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CELL_WIDTH  = 1'b0,
		REG_CELL_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic              start;
		logic [SUM_W-1:0]  dividend;
		logic [CELL_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [SUM_W-1:0]  quot;
		logic [CELL_W-1:0] rem;
	} div_rsp_t;

endpackage

/* rtl/rogw_if.sv */
// rogw_cmd_if and rogw_res_if: valid/ready channels for commands and results
// depends on rogw_pkg for the field widths
`timescale 1ns / 1ps

interface rogw_cmd_if import rogw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [POS_W-1:0]  rect_left;
	logic [POS_W-1:0]  rect_top;
	logic [POS_W-1:0]  rect_width;
	logic [POS_W-1:0]  rect_height;

	modport source (
		output valid, kind, rect_left, rect_top, rect_width, rect_height,
		input  ready
	);
	modport sink (
		input  valid, kind, rect_left, rect_top, rect_width, rect_height,
		output ready
	);
endinterface

interface rogw_res_if import rogw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [GRID_W-1:0] grid_left;
	logic [GRID_W-1:0] grid_top;
	logic [GRID_W-1:0] grid_width;
	logic [GRID_W-1:0] grid_height;
	logic [CHG_W-1:0]  cells_changed;
	logic [WGT_W-1:0]  cell_weight;

	modport source (
		output valid, grid_left, grid_top, grid_width, grid_height, cells_changed, cell_weight,
		input  ready
	);
	modport sink (
		input  valid, grid_left, grid_top, grid_width, grid_height, cells_changed, cell_weight,
		output ready
	);
endinterface

/* rtl/rogw_div.sv */
// rogw_div: restoring divider, one quotient bit per cycle
// depends on rogw_pkg (div_req_t, div_rsp_t); divisor must be nonzero
`timescale 1ns / 1ps

module rogw_div import rogw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(SUM_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SUM_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  dq_q;
	logic [CELL_W-1:0] rem_q;
	logic [CELL_W-1:0] dvs_q;

	logic [CELL_W:0] trial;
	logic [CELL_W:0] diff;
	logic            ge;

	// shift in the next dividend bit and try a subtract
	assign trial = {rem_q, dq_q[SUM_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q  <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[SUM_W-2:0], ge};
			rem_q <= ge ? diff[CELL_W-1:0] : trial[CELL_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = dq_q;
	assign rsp.rem  = rem_q;

endmodule

/* rtl/rect_occupancy_grid_weights.sv */
// rect_occupancy_grid_weights: per-cell obstacle weight grid updated by pixel rectangles
// add/remove: four divisions snap the rectangle edges to cells, then a one-cell-per-cycle
// read-modify-write walk over the weight ram, skipped if the snapped rectangle misses the grid
// read and unused kind skip the divisions; one transaction at a time, walk set by the single ram read port
// reset: cell size registers go to 32, then a clearing pass zeroes the ram, one entry per cycle,
// CELL_COUNT (4096) entries with cmd.ready low; configuration writes are taken during the pass
`timescale 1ns / 1ps

module rect_occupancy_grid_weights import rogw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	rogw_cmd_if.sink              cmd,
	rogw_res_if.source            res
);

	// control sequencer states
	typedef enum logic [9:0] {
		ST_CLEAR    = 10'b0000000001,
		ST_IDLE     = 10'b0000000010,
		ST_DIV_GO   = 10'b0000000100,
		ST_DIV_WAIT = 10'b0000001000,
		ST_SNAP     = 10'b0000010000,
		ST_BOUNDS   = 10'b0000100000,
		ST_WALK     = 10'b0001000000,
		ST_DRAIN    = 10'b0010000000,
		ST_RD_WAIT  = 10'b0100000000,
		ST_RESULT   = 10'b1000000000
	} state_t;

	localparam logic [1:0] STEP_LAST = 2'd3;

	state_t state_q;

	// configuration registers
	logic [CELL_W-1:0] cell_w_q;
	logic [CELL_W-1:0] cell_h_q;

	// captured command
	kind_t            op_q;
	logic [POS_W-1:0] left_q;
	logic [POS_W-1:0] top_q;
	logic [POS_W-1:0] wid_q;
	logic [POS_W-1:0] hgt_q;
	logic             rd_hit_q;

	// snapping: step 0 left edge, 1 right edge, 2 top edge, 3 bottom edge
	logic [1:0]        step_q;
	logic [SPAN_W-1:0] lo_col_q;
	logic [SPAN_W-1:0] hi_col_q;
	logic [SPAN_W-1:0] lo_row_q;
	logic [SPAN_W-1:0] hi_row_q;

	// snapped rectangle and counters that go out with the result
	logic [GRID_W-1:0] gl_q;
	logic [GRID_W-1:0] gt_q;
	logic [GRID_W-1:0] gw_q;
	logic [GRID_W-1:0] gh_q;
	logic [CHG_W-1:0]  changed_q;
	logic [WGT_W-1:0]  weight_q;

	// cell walk
	logic [COL_W-1:0]  col_q;
	logic [COL_W-1:0]  first_col_q;
	logic [COL_W-1:0]  last_col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ROW_W-1:0]  last_row_q;
	logic [ADDR_W-1:0] row_base_q;

	// clearing pass address
	logic [ADDR_W-1:0] clr_addr_q;

	// write-back stage of the read-modify-write
	logic              wr_pend_s1;
	logic [ADDR_W-1:0] wr_addr_s1;

	// weight ram
	logic [WGT_W-1:0]  mem [CELL_COUNT];
	logic [WGT_W-1:0]  rd_data_q;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [WGT_W-1:0]  mem_wdata;
	logic [WGT_W-1:0]  mod_weight;

	// result register
	logic              res_valid_q;
	logic              res_load;
	logic [GRID_W-1:0] res_gl_q;
	logic [GRID_W-1:0] res_gt_q;
	logic [GRID_W-1:0] res_gw_q;
	logic [GRID_W-1:0] res_gh_q;
	logic [CHG_W-1:0]  res_chg_q;
	logic [WGT_W-1:0]  res_wgt_q;

	// divider hookup
	div_req_t div_req;
	div_rsp_t div_rsp;

	logic              cmd_fire;
	logic              rd_in_grid;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] walk_addr;
	logic              walk_row_end;

	logic [SUM_W-1:0]  dvd;
	logic [CELL_W-1:0] dvs_raw;
	logic [CELL_W-1:0] dvs;
	logic [CELL_W+2:0] five_rem;
	logic              round_up;
	logic [SPAN_W-1:0] snapped;

	logic [SPAN_W-1:0] col_end;
	logic [SPAN_W-1:0] row_end;
	logic [SPAN_W-1:0] col_lim;
	logic [SPAN_W-1:0] row_lim;
	logic              col_in;
	logic              row_in;

	// ---------------------------------------------------------------- handshake
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;

	// a read of a cell outside the grid returns zero without touching the ram
	assign rd_in_grid = (cmd.rect_left < POS_W'(GRID_COLUMNS)) && (cmd.rect_top < POS_W'(GRID_ROWS));
	assign rd_addr    = ADDR_W'(cmd.rect_top[ROW_W-1:0] * GRID_COLUMNS)
		+ ADDR_W'(cmd.rect_left[COL_W-1:0]);

	// ---------------------------------------------------------------- divider operands
	always_comb begin
		case (step_q)
			2'd0:    dvd = SUM_W'(left_q);
			2'd1:    dvd = SUM_W'(left_q) + SUM_W'(wid_q);
			2'd2:    dvd = SUM_W'(top_q);
			default: dvd = SUM_W'(top_q) + SUM_W'(hgt_q);
		endcase
	end

	// steps 0 and 1 use the cell width, 2 and 3 the cell height; a zero size acts as one
	assign dvs_raw = step_q[1] ? cell_h_q : cell_w_q;
	assign dvs     = (dvs_raw == '0) ? CELL_W'(1) : dvs_raw;

	assign div_req.start    = (state_q == ST_DIV_GO);
	assign div_req.dividend = dvd;
	assign div_req.divisor  = dvs;

	rogw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// lower edges round up past 0.8 of a cell, upper edges past 0.2 of a cell
	assign five_rem = {1'b0, div_rsp.rem, 2'b00} + {3'b000, div_rsp.rem};
	assign round_up = step_q[0] ? (five_rem > {3'b000, dvs})
		: (five_rem > {1'b0, dvs, 2'b00});
	assign snapped  = {1'b0, div_rsp.quot} + SPAN_W'(round_up);

	// ---------------------------------------------------------------- walk bounds, clipped to the grid
	assign col_end = {1'b0, gl_q} + {1'b0, gw_q};
	assign row_end = {1'b0, gt_q} + {1'b0, gh_q};
	assign col_lim = (col_end > SPAN_W'(GRID_COLUMNS)) ? SPAN_W'(GRID_COLUMNS) : col_end;
	assign row_lim = (row_end > SPAN_W'(GRID_ROWS)) ? SPAN_W'(GRID_ROWS) : row_end;
	assign col_in  = gl_q < GRID_W'(GRID_COLUMNS);
	assign row_in  = gt_q < GRID_W'(GRID_ROWS);

	assign walk_addr    = row_base_q + ADDR_W'(col_q);
	assign walk_row_end = (col_q == last_col_q);

	// ---------------------------------------------------------------- ram ports
	// the walk issues one read per cycle and writes the modified weight back in the cycle after;
	// consecutive addresses differ, so a read never meets a pending write to the same cell
	assign mem_re    = (state_q == ST_WALK) || (cmd_fire && (cmd.kind == KIND_READ) && rd_in_grid);
	assign mem_raddr = (state_q == ST_WALK) ? walk_addr : rd_addr;

	always_comb begin
		if (op_q == KIND_ADD) begin
			mod_weight = (rd_data_q == WGT_MAX) ? rd_data_q : rd_data_q + WGT_W'(1);
		end else begin
			mod_weight = (rd_data_q == '0) ? rd_data_q : rd_data_q - WGT_W'(1);
		end
	end

	assign mem_we    = (state_q == ST_CLEAR) || wr_pend_s1;
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_addr_q : wr_addr_s1;
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : mod_weight;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	// ---------------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_w_q <= CELL_W'(32);
			cell_h_q <= CELL_W'(32);
		end else if (cfg_write) begin
			case (reg_idx_t'(cfg_index))
				REG_CELL_WIDTH:  cell_w_q <= cfg_data;
				REG_CELL_HEIGHT: cell_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- sequencer
	assign res_load = (state_q == ST_RESULT) && (!res_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			step_q      <= '0;
			wr_pend_s1  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			wr_pend_s1 <= (state_q == ST_WALK);

			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
					if (clr_addr_q == ADDR_W'(CELL_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_fire) begin
						step_q <= '0;
						case (kind_t'(cmd.kind))
							KIND_ADD, KIND_REMOVE: state_q <= ST_DIV_GO;
							KIND_READ:             state_q <= ST_RD_WAIT;
							default:               state_q <= ST_RESULT;
						endcase
					end
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_rsp.done) begin
						if (step_q == STEP_LAST) begin
							state_q <= ST_SNAP;
						end else begin
							step_q  <= step_q + 2'd1;
							state_q <= ST_DIV_GO;
						end
					end
				end
				ST_SNAP: begin
					state_q <= ST_BOUNDS;
				end
				ST_BOUNDS: begin
					state_q <= (col_in && row_in) ? ST_WALK : ST_RESULT;
				end
				ST_WALK: begin
					if (walk_row_end && (row_q == last_row_q)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// last write-back lands at this edge
					state_q <= ST_RESULT;
				end
				ST_RD_WAIT: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------- datapath registers
	always_ff @(posedge clk) begin
		wr_addr_s1 <= walk_addr;

		case (state_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					op_q      <= kind_t'(cmd.kind);
					left_q    <= cmd.rect_left;
					top_q     <= cmd.rect_top;
					wid_q     <= cmd.rect_width;
					hgt_q     <= cmd.rect_height;
					rd_hit_q  <= rd_in_grid;
					changed_q <= '0;
					weight_q  <= '0;
					gw_q      <= GRID_W'(1);
					gh_q      <= GRID_W'(1);
					// a read echoes the column and row; the unused kind reports zero
					if (cmd.kind == KIND_READ) begin
						gl_q <= GRID_W'(cmd.rect_left);
						gt_q <= GRID_W'(cmd.rect_top);
					end else begin
						gl_q <= '0;
						gt_q <= '0;
					end
				end
			end
			ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					case (step_q)
						2'd0:    lo_col_q <= snapped;
						2'd1:    hi_col_q <= snapped;
						2'd2:    lo_row_q <= snapped;
						default: hi_row_q <= snapped;
					endcase
				end
			end
			ST_SNAP: begin
				gl_q <= lo_col_q[GRID_W-1:0];
				gt_q <= lo_row_q[GRID_W-1:0];
				gw_q <= (hi_col_q > lo_col_q) ? GRID_W'(hi_col_q - lo_col_q) : GRID_W'(1);
				gh_q <= (hi_row_q > lo_row_q) ? GRID_W'(hi_row_q - lo_row_q) : GRID_W'(1);
			end
			ST_BOUNDS: begin
				col_q       <= gl_q[COL_W-1:0];
				first_col_q <= gl_q[COL_W-1:0];
				last_col_q  <= COL_W'(col_lim - SPAN_W'(1));
				row_q       <= gt_q[ROW_W-1:0];
				last_row_q  <= ROW_W'(row_lim - SPAN_W'(1));
				row_base_q  <= ADDR_W'(gt_q[ROW_W-1:0] * GRID_COLUMNS);
			end
			ST_WALK: begin
				// every visited cell counts, even one already at its limit
				if (changed_q != CHG_MAX) begin
					changed_q <= changed_q + CHG_W'(1);
				end
				if (walk_row_end) begin
					col_q      <= first_col_q;
					row_q      <= row_q + ROW_W'(1);
					row_base_q <= row_base_q + ADDR_W'(GRID_COLUMNS);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
			ST_RD_WAIT: begin
				weight_q <= rd_hit_q ? rd_data_q : '0;
			end
			default: ;
		endcase

		if (res_load) begin
			res_gl_q  <= gl_q;
			res_gt_q  <= gt_q;
			res_gw_q  <= gw_q;
			res_gh_q  <= gh_q;
			res_chg_q <= changed_q;
			res_wgt_q <= weight_q;
		end
	end

	// ---------------------------------------------------------------- result channel
	assign res.valid         = res_valid_q;
	assign res.grid_left     = res_gl_q;
	assign res.grid_top      = res_gt_q;
	assign res.grid_width    = res_gw_q;
	assign res.grid_height   = res_gh_q;
	assign res.cells_changed = res_chg_q;
	assign res.cell_weight   = res_wgt_q;

endmodule

/* tb/grid_weight_checker.sv */
// grid_weight_checker: watches the command, result and register ports of the occupancy grid
// keeps its own weight map and cell sizes; depends on rogw_pkg and the rogw channel interfaces
`timescale 1ns / 1ps

module grid_weight_checker import rogw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	rogw_cmd_if                   cmd,
	rogw_res_if                   res,
	output int                    mismatch_count,
	output int                    pending_results
);

	typedef struct packed {
		logic [GRID_W-1:0] left;
		logic [GRID_W-1:0] top;
		logic [GRID_W-1:0] width;
		logic [GRID_W-1:0] height;
		logic [CHG_W-1:0]  changed;
		logic [WGT_W-1:0]  weight;
	} grid_result_t;

	grid_result_t      predicted_results[$];
	logic [WGT_W-1:0]  weight_map [CELL_COUNT];
	logic [CELL_W-1:0] cell_w_px;
	logic [CELL_W-1:0] cell_h_px;

	initial begin
		mismatch_count  = 0;
		pending_results = 0;
	end

	// pixel span to first cell and cell count, lower edge rounds at 0.8, upper at 0.2
	function automatic void snap_axis(input int unsigned pos, input int unsigned len,
			input int unsigned cellsz, output int unsigned first, output int unsigned span);
		int unsigned c, hi, lo_cell, hi_cell;
		c       = (cellsz == 0) ? 1 : cellsz;
		hi      = pos + len;
		lo_cell = pos / c;
		hi_cell = hi / c;
		if (5 * (pos % c) > 4 * c)
			lo_cell++;
		if (5 * (hi % c) > c)
			hi_cell++;
		first = lo_cell;
		span  = (hi_cell > lo_cell) ? hi_cell - lo_cell : 1;
	endfunction

	function automatic grid_result_t predict_grid_result(input kind_t k,
			input int unsigned left, input int unsigned top,
			input int unsigned w, input int unsigned h);
		grid_result_t r;
		int unsigned  gl, gt, gw, gh, c_end, r_end, changed, weight, idx, row, col;
		gl      = 0;
		gt      = 0;
		gw      = 1;
		gh      = 1;
		changed = 0;
		weight  = 0;
		case (k)
			KIND_ADD, KIND_REMOVE: begin
				snap_axis(left, w, cell_w_px, gl, gw);
				snap_axis(top, h, cell_h_px, gt, gh);
				c_end = gl + gw;
				r_end = gt + gh;
				if (c_end > GRID_COLUMNS)
					c_end = GRID_COLUMNS;
				if (r_end > GRID_ROWS)
					r_end = GRID_ROWS;
				for (row = gt; row < r_end; row++) begin
					for (col = gl; col < c_end; col++) begin
						idx = row * GRID_COLUMNS + col;
						if (k == KIND_ADD && weight_map[idx] != WGT_MAX)
							weight_map[idx] = weight_map[idx] + 1'b1;
						else if (k == KIND_REMOVE && weight_map[idx] != '0)
							weight_map[idx] = weight_map[idx] - 1'b1;
						if (changed < CHG_MAX)
							changed++;
					end
				end
			end
			KIND_READ: begin
				gl = left;
				gt = top;
				if (left < GRID_COLUMNS && top < GRID_ROWS)
					weight = weight_map[top * GRID_COLUMNS + left];
			end
			default: begin
			end
		endcase
		r.left    = GRID_W'(gl);
		r.top     = GRID_W'(gt);
		r.width   = GRID_W'(gw);
		r.height  = GRID_W'(gh);
		r.changed = CHG_W'(changed);
		r.weight  = WGT_W'(weight);
		return r;
	endfunction

	task automatic check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatch_count++;
			$display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		grid_result_t want, got;
		if (!arst_n) begin
			predicted_results.delete();
			for (int i = 0; i < CELL_COUNT; i++)
				weight_map[i] = '0;
			cell_w_px       = CELL_W'(32);
			cell_h_px       = CELL_W'(32);
			pending_results = 0;
		end else begin
			if (res.valid && res.ready) begin
				got.left    = res.grid_left;
				got.top     = res.grid_top;
				got.width   = res.grid_width;
				got.height  = res.grid_height;
				got.changed = res.cells_changed;
				got.weight  = res.cell_weight;
				if (predicted_results.size() == 0) begin
					mismatch_count++;
					$display("%0t: result with no command outstanding, actual %h", $time, got);
				end else begin
					want = predicted_results.pop_front();
					check_field("grid_left", want.left, got.left);
					check_field("grid_top", want.top, got.top);
					check_field("grid_width", want.width, got.width);
					check_field("grid_height", want.height, got.height);
					check_field("cells_changed", want.changed, got.changed);
					check_field("cell_weight", want.weight, got.weight);
				end
			end
			if (cmd.valid && cmd.ready)
				predicted_results.push_back(predict_grid_result(kind_t'(cmd.kind),
					cmd.rect_left, cmd.rect_top, cmd.rect_width, cmd.rect_height));
			if (cfg_write) begin
				case (reg_idx_t'(cfg_index))
					REG_CELL_WIDTH:  cell_w_px = cfg_data;
					REG_CELL_HEIGHT: cell_h_px = cfg_data;
					default: begin
					end
				endcase
			end
			pending_results = predicted_results.size();
		end
	end

endmodule

/* tb/rect_occupancy_grid_weights_test.sv */
// rect_occupancy_grid_weights_test: stimulus and verdict for the occupancy grid block
// drives rectangles, reads and cell sizes; grid_weight_checker predicts and compares
`timescale 1ns / 1ps

module rect_occupancy_grid_weights_test;
	import rogw_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rogw_cmd_if cmd_ch ();
	rogw_res_if res_ch ();

	int mismatch_count;
	int pending_results;

	// sender burst bookkeeping
	int burst_left = 0;

	// receiver pattern and long hold-off bookkeeping
	int hold_off_asks = 0;
	int hold_off_seen = 0;
	int hold_off_left = 0;
	int rx_mode       = 0;
	int rx_mode_left  = 0;

	// cell size settings of the random phases, the last one is drawn at run time
	localparam int PHASES = 6;
	int unsigned phase_cw [PHASES] = '{1, 0, 1024, 2047, 13, 0};
	int unsigned phase_ch [PHASES] = '{1, 0, 1024, 3, 100, 0};

	rect_occupancy_grid_weights DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.res       (res_ch)
	);

	grid_weight_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.cmd             (cmd_ch),
		.res             (res_ch),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results)
	);

	always #4 clk = ~clk;

	// hard stop well beyond the slowest legal run
	initial begin
		#150_000_000;
		$display("FAIL");
		$finish;
	end

	// result side: modes of random stalls, plus a long hold-off whenever stimulus asks for one
	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			res_ch.ready <= 1'b0;
			hold_off_left--;
		end else if (hold_off_seen != hold_off_asks) begin
			// long stretch so the block backs up and stalls the command side
			hold_off_seen = hold_off_asks;
			hold_off_left = 1000;
			res_ch.ready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode      = $urandom_range(0, 3);
				rx_mode_left = $urandom_range(16, 256);
			end
			rx_mode_left--;
			case (rx_mode)
				0:       res_ch.ready <= 1'b1;
				1:       res_ch.ready <= 1'($urandom_range(0, 1));
				2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
				default: res_ch.ready <= ($urandom_range(0, 15) != 0);
			endcase
		end
	end

	// offer one command transaction, in bursts with random gaps in between
	task automatic send_command(input kind_t k, input int unsigned l, input int unsigned t,
			input int unsigned w, input int unsigned h);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			repeat (gap) begin
				@(negedge clk);
				cmd_ch.valid <= 1'b0;
			end
			// mostly short bursts, now and then a long one with no idling
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
		end
		@(negedge clk);
		cmd_ch.valid       <= 1'b1;
		cmd_ch.kind        <= k;
		cmd_ch.rect_left   <= POS_W'(l);
		cmd_ch.rect_top    <= POS_W'(t);
		cmd_ch.rect_width  <= POS_W'(w);
		cmd_ch.rect_height <= POS_W'(h);
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		burst_left--;
	endtask

	// drop valid and let the block drain before touching the registers
	task automatic wait_idle();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending_results != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_cell_size(input int unsigned cw, input int unsigned ch);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= REG_CELL_WIDTH;
		cfg_data  <= CFG_DATA_W'(cw);
		@(negedge clk);
		cfg_index <= REG_CELL_HEIGHT;
		cfg_data  <= CFG_DATA_W'(ch);
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// pixel position mostly over the grid and a little past it, sometimes anywhere
	function automatic int unsigned pick_pos(input int unsigned cellsz, input int unsigned cells);
		int unsigned span;
		if ($urandom_range(0, 19) == 0)
			return $urandom & 32'h7fff;
		span = cellsz * (cells + 2);
		if (span > 32767)
			span = 32767;
		return $urandom_range(0, span);
	endfunction

	// mostly a few cells long, some tiny, rarely any 15-bit length
	function automatic int unsigned pick_len(input int unsigned cellsz);
		int unsigned sel, len;
		sel = $urandom_range(0, 39);
		if (sel == 0)
			len = $urandom & 32'h7fff;
		else if (sel < 5)
			len = $urandom_range(0, 3);
		else
			len = $urandom_range(0, 3 * cellsz);
		if (len > 32767)
			len = 32767;
		return len;
	endfunction

	task automatic random_command(input int unsigned cw, input int unsigned ch);
		int unsigned sel, l, t, w, h;
		kind_t       k;
		sel = $urandom_range(0, 99);
		k = (sel < 40) ? KIND_ADD : (sel < 70) ? KIND_REMOVE : (sel < 95) ? KIND_READ : KIND_NONE;
		if (k == KIND_READ || k == KIND_NONE) begin
			// cell address near the grid, sometimes anything; size fields are don't-care
			l = ($urandom_range(0, 9) == 0) ? ($urandom & 32'h7fff) : $urandom_range(0, GRID_COLUMNS + 4);
			t = ($urandom_range(0, 9) == 0) ? ($urandom & 32'h7fff) : $urandom_range(0, GRID_ROWS + 4);
			w = $urandom & 32'h7fff;
			h = $urandom & 32'h7fff;
		end else begin
			l = pick_pos(cw, GRID_COLUMNS);
			t = pick_pos(ch, GRID_ROWS);
			w = pick_len(cw);
			h = pick_len(ch);
		end
		send_command(k, l, t, w, h);
	endtask

	initial begin
		int          sel;
		int unsigned cw, ch;

		// every block input known from time zero
		arst_n              = 1'b0;
		cfg_write           = 1'b0;
		cfg_index           = REG_CELL_WIDTH;
		cfg_data            = '0;
		cmd_ch.valid        = 1'b0;
		cmd_ch.kind         = KIND_ADD;
		cmd_ch.rect_left    = '0;
		cmd_ch.rect_top     = '0;
		cmd_ch.rect_width   = '0;
		cmd_ch.rect_height  = '0;
		res_ch.ready        = 1'b0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// register writes land during the clearing pass
		set_cell_size(32, 32);

		// directed part with 32 x 32 pixel cells
		send_command(KIND_READ, 0, 0, 0, 0);
		// remove on an empty cell stays at zero
		send_command(KIND_REMOVE, 160, 160, 10, 10);
		send_command(KIND_READ, 5, 5, 32767, 32767);
		// whole grid, every cell once
		send_command(KIND_ADD, 0, 0, 2048, 2048);
		// all field bits high, lands past the grid
		send_command(KIND_ADD, 32767, 32767, 32767, 32767);
		// zero size still covers one cell
		send_command(KIND_ADD, 40, 40, 0, 0);
		// lower remainder just over 0.8 of a cell rounds up, just under does not
		send_command(KIND_ADD, 122, 64, 32, 32);
		send_command(KIND_ADD, 121, 64, 32, 32);
		// upper remainder just over 0.2 of a cell rounds up, just under does not
		send_command(KIND_ADD, 64, 200, 71, 32);
		send_command(KIND_ADD, 64, 200, 70, 32);
		send_command(KIND_READ, 3, 2, 0, 0);
		send_command(KIND_READ, 4, 2, 0, 0);
		send_command(KIND_REMOVE, 122, 64, 32, 32);
		// crosses the grid edge, only the inside part counts
		send_command(KIND_ADD, 1900, 1900, 400, 400);
		// last cell only
		send_command(KIND_ADD, 2016, 2016, 32, 32);
		send_command(KIND_READ, 63, 63, 0, 0);
		// reads outside the grid
		send_command(KIND_READ, 64, 0, 0, 0);
		send_command(KIND_READ, 0, 64, 0, 0);
		send_command(KIND_READ, 32767, 32767, 32767, 32767);
		// unused kind
		send_command(KIND_NONE, 32767, 32767, 32767, 32767);
		send_command(KIND_NONE, 0, 0, 0, 0);
		// whole grid back down
		send_command(KIND_REMOVE, 0, 0, 32767, 32767);
		send_command(KIND_READ, 0, 0, 0, 0);

		// hot spot around the corner cell, enough adds to pin it at full weight
		for (int i = 0; i < 320; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 90)
				send_command(KIND_ADD, $urandom_range(0, 20), $urandom_range(0, 20),
					$urandom_range(0, 40), $urandom_range(0, 40));
			else if (sel < 93)
				send_command(KIND_REMOVE, $urandom_range(0, 20), $urandom_range(0, 20),
					$urandom_range(0, 40), $urandom_range(0, 40));
			else
				send_command(KIND_READ, $urandom_range(0, 2), $urandom_range(0, 2), 0, 0);
		end

		// random phases over a range of cell sizes, zero size among them
		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			cw = phase_cw[p];
			ch = phase_ch[p];
			if (p == PHASES - 1) begin
				cw = $urandom_range(1, 1024);
				ch = $urandom_range(1, 1024);
			end
			set_cell_size(cw, ch);
			if (cw == 0)
				cw = 1;
			if (ch == 0)
				ch = 1;
			for (int i = 0; i < 140; i++) begin
				// one long result-side hold-off while commands keep coming
				if (p == 0 && i == 5)
					hold_off_asks++;
				random_command(cw, ch);
			end
		end

		// drain and give stray results a chance to show up
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);

		if (mismatch_count == 0 && pending_results == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
